[sv/bpct_pkg.sv]
`timescale 1ns / 1ps
// package for the binary prefix counter trie: operation codes, controller states,
// default sizes and the control structs between the trie modules
// no dependencies
package bpct_pkg;

   // default sizes, handed down to the top-level parameters
   localparam int KEY_BITS_DEF   = 8;
   localparam int COUNT_BITS_DEF = 16;

   // fixed port field widths
   localparam int OPERATION_W = 2;
   localparam int KEY_W       = 8;
   localparam int LEVEL_W     = 3;
   localparam int LEVEL_MAX_W = 16;

   typedef enum logic [OPERATION_W-1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WALK,
      ST_WIPE,
      ST_FINISH
   } state_type;

   // link between neighboring level cells
   typedef struct packed {
      logic step;   // insert token for this level
      logic wipe;   // sweep write of zero at the shared sweep address
   } cell_ctl_type;

   // control of the key presence memory
   typedef struct packed {
      logic rd;
      logic wr;
      logic wipe;
   } mark_ctl_type;

endpackage

[sv/bpct_cell.sv]
`timescale 1ns / 1ps
// one trie level: counter memory for the 2^LEVEL prefix nodes and the level maximum
// depends on bpct_pkg
module bpct_cell #(
   parameter int KEY_BITS   = bpct_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = bpct_pkg::COUNT_BITS_DEF,
   parameter int LEVEL      = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpct_pkg::cell_ctl_type ctl_in,
   input  logic [KEY_BITS-1:0]    key_in,
   input  logic [KEY_BITS-1:0]    wipe_addr_in,
   output bpct_pkg::cell_ctl_type ctl_out,
   output logic [KEY_BITS-1:0]    key_out,
   output logic [COUNT_BITS-1:0]  max_out
);
   import bpct_pkg::*;

   localparam int DEPTH = 1 << LEVEL;
   localparam int AW    = (LEVEL == 0) ? 1 : LEVEL;

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [AW-1:0]         rd_idx;
   logic [AW-1:0]         wipe_idx;
   logic [AW-1:0]         addr_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  step_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] bump_in;
   logic [COUNT_BITS-1:0] max_ff;
   logic [COUNT_BITS-1:0] max_in;

   // node index is the top LEVEL bits of the key
   assign rd_idx   = AW'(key_in >> (KEY_BITS - LEVEL));
   assign wipe_idx = (LEVEL == 0) ? '0 : AW'(wipe_addr_in);

   // saturating increment of the node count read last cycle
   assign bump_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   always_comb begin
      max_in = max_ff;
      if (ctl_in.wipe) begin
         max_in = '0;
      end else if (step_ff && (bump_in > max_ff)) begin
         max_in = bump_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.wipe) begin
         mem[wipe_idx] <= '0;
      end else if (step_ff) begin
         mem[addr_ff] <= bump_in;
      end
      if (ctl_in.step) begin
         count_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         max_ff  <= '0;
      end else begin
         step_ff <= ctl_in.step;
         max_ff  <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.step) begin
         addr_ff <= rd_idx;
         key_ff  <= key_in;
      end
   end

   assign ctl_out.step = step_ff;
   assign ctl_out.wipe = ctl_in.wipe;
   assign key_out      = key_ff;
   assign max_out      = max_ff;

`ifndef SYNTHESIS
   a_no_wipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      step_ff |-> !ctl_in.wipe)
      else $error("sweep collides with a counter update");

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      step_ff |=> !step_ff)
      else $error("second insert token behind the first");

   a_max_monotone: assert property (@(posedge clock) disable iff (reset)
      !ctl_in.wipe |=> max_ff >= $past(max_ff))
      else $error("level maximum dropped without a clear");
`endif

endmodule

[sv/bpct_mark.sv]
`timescale 1ns / 1ps
// key presence memory: one mark per full key, registered read
// depends on bpct_pkg
module bpct_mark #(
   parameter int KEY_BITS = bpct_pkg::KEY_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpct_pkg::mark_ctl_type ctl_in,
   input  logic [KEY_BITS-1:0]    key_in,
   input  logic [KEY_BITS-1:0]    wipe_addr_in,
   output logic                   found_out
);
   import bpct_pkg::*;

   localparam int DEPTH = 1 << KEY_BITS;

   logic mem [DEPTH];
   logic found_ff;

   always_ff @(posedge clock) begin
      if (ctl_in.wipe) begin
         mem[wipe_addr_in] <= 1'b0;
      end else if (ctl_in.wr) begin
         mem[key_in] <= 1'b1;
      end
      if (ctl_in.rd) begin
         found_ff <= mem[key_in];
      end
   end

   assign found_out = found_ff;

`ifndef SYNTHESIS
   a_wr_not_wipe: assert property (@(posedge clock) disable iff (reset)
      ctl_in.wr |-> !ctl_in.wipe)
      else $error("mark write during sweep");

   a_rd_not_wr: assert property (@(posedge clock) disable iff (reset)
      ctl_in.rd |-> !ctl_in.wr && !ctl_in.wipe)
      else $error("mark read overlaps a write");

   a_rd_single: assert property (@(posedge clock) disable iff (reset)
      ctl_in.rd |=> !ctl_in.rd)
      else $error("back to back mark reads");
`endif

endmodule

[sv/binary_prefix_counter_trie.sv]
`timescale 1ns / 1ps
// binary prefix counter trie, one item at a time, result held in an output register
// insert walks the key down the chain of level cells (one cell per level), then finishes;
// find reads the mark memory, clear sweeps all memories, an unused code goes straight to
// the finish state; the next beat is taken the cycle after the result is loaded into the
// output register
// reset: a sweep over every address zeroes all counter and mark memories, req_stall high
module binary_prefix_counter_trie #(
   parameter int KEY_BITS   = bpct_pkg::KEY_BITS_DEF,
   parameter int COUNT_BITS = bpct_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bpct_pkg::OPERATION_W-1:0] req_operation,
   input  logic [bpct_pkg::KEY_W-1:0]       req_key,
   input  logic [bpct_pkg::LEVEL_W-1:0]     req_level,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [bpct_pkg::LEVEL_MAX_W-1:0] rsp_level_max
);
   import bpct_pkg::*;

   localparam int LVL_AW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   // controller state
   state_type           state_ff;
   state_type           state_in;
   logic                pending_ff;      // a request waits for its result
   logic [KEY_BITS-1:0] wipe_cnt_ff;     // sweep address, wraps to zero at the end
   logic                wipe_last;

   // captured request beat
   op_type              op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [LEVEL_W-1:0]  level_ff;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [LEVEL_MAX_W-1:0] rsp_level_max_ff;
   logic                   slot_free;
   logic                   load_rsp;

   // chain of level cells
   cell_ctl_type          launch_ctl;
   cell_ctl_type          link     [KEY_BITS+1];
   logic [KEY_BITS-1:0]   key_link [KEY_BITS+1];
   logic [COUNT_BITS-1:0] maxima   [KEY_BITS];

   mark_ctl_type mark_ctl;
   logic         mark_found;
   logic         accept;

   // result selection
   logic [LVL_AW-1:0]      lvl_idx;
   logic                   lvl_ok;
   logic [COUNT_BITS-1:0]  max_sel;
   logic [LEVEL_MAX_W-1:0] level_max_sel;
   logic                   found_sel;

   assign accept    = req_valid && !req_stall;
   assign wipe_last = (wipe_cnt_ff == '1);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_INSERT: state_in = ST_LAUNCH;
                  OP_FIND:   state_in = ST_LAUNCH;
                  OP_CLEAR:  state_in = ST_WIPE;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_LAUNCH: begin
            state_in = (op_ff == OP_INSERT) ? ST_WALK : ST_FINISH;
         end
         ST_WALK: begin
            // last level cell is writing back its counter
            if (link[KEY_BITS].step) begin
               state_in = ST_FINISH;
            end
         end
         ST_WIPE: begin
            if (wipe_last) begin
               state_in = pending_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall       = 1'b1;
      launch_ctl.step = 1'b0;
      launch_ctl.wipe = 1'b0;
      mark_ctl.rd     = 1'b0;
      mark_ctl.wr     = 1'b0;
      mark_ctl.wipe   = 1'b0;
      load_rsp        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_LAUNCH: begin
            // insert sends a token down the chain and marks the key,
            // find reads the mark
            launch_ctl.step = (op_ff == OP_INSERT);
            mark_ctl.wr     = (op_ff == OP_INSERT);
            mark_ctl.rd     = (op_ff == OP_FIND);
         end
         ST_WALK: begin
         end
         ST_WIPE: begin
            launch_ctl.wipe = 1'b1;
            mark_ctl.wipe   = 1'b1;
         end
         ST_FINISH: begin
            load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WIPE;
         pending_ff  <= 1'b0;
         wipe_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pending_ff <= 1'b1;
         end else if (load_rsp) begin
            pending_ff <= 1'b0;
         end
         if (state_ff == ST_WIPE) begin
            wipe_cnt_ff <= wipe_cnt_ff + 1'b1;
         end
      end
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= KEY_BITS'(req_key);
         level_ff <= req_level;
      end
   end

   assign link[0]     = launch_ctl;
   assign key_link[0] = key_ff;

   for (genvar l = 0; l < KEY_BITS; l++) begin : g_level
      bpct_cell #(
         .KEY_BITS   (KEY_BITS),
         .COUNT_BITS (COUNT_BITS),
         .LEVEL      (l)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl_in       (link[l]),
         .key_in       (key_link[l]),
         .wipe_addr_in (wipe_cnt_ff),
         .ctl_out      (link[l+1]),
         .key_out      (key_link[l+1]),
         .max_out      (maxima[l])
      );
   end

   bpct_mark #(
      .KEY_BITS (KEY_BITS)
   ) u_mark (
      .clock        (clock),
      .reset        (reset),
      .ctl_in       (mark_ctl),
      .key_in       (key_ff),
      .wipe_addr_in (wipe_cnt_ff),
      .found_out    (mark_found)
   );

   // requested level maximum; a level past the trie depth reports zero,
   // a wide count saturates to the field
   assign lvl_idx = LVL_AW'(level_ff);
   assign lvl_ok  = (32'(level_ff) < KEY_BITS);
   assign max_sel = lvl_ok ? maxima[lvl_idx] : '0;

   always_comb begin
      if ((COUNT_BITS > LEVEL_MAX_W) && ((max_sel >> LEVEL_MAX_W) != '0)) begin
         level_max_sel = '1;
      end else begin
         level_max_sel = LEVEL_MAX_W'(max_sel);
      end
   end

   assign found_sel = (op_ff == OP_FIND) && mark_found;

   // output register, frees the request side while a result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff     <= found_sel;
         rsp_level_max_ff <= level_max_sel;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_level_max = rsp_level_max_ff;

`ifndef SYNTHESIS
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("second beat taken while one is in flight");

   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      link[KEY_BITS].step |-> state_ff == ST_WALK)
      else $error("insert token left the chain outside the walk");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      load_rsp && op_ff == OP_CLEAR |-> level_max_sel == '0)
      else $error("level maximum not zero after clear");

   a_found_find_only: assert property (@(posedge clock) disable iff (reset)
      load_rsp && op_ff != OP_FIND |-> !found_sel)
      else $error("found raised for an operation other than find");

   a_finish_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> pending_ff)
      else $error("result produced with no request pending");
`endif

endmodule
